// ===== src/ipv4mt_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the trie table.
`default_nettype none
package ipv4mt_pkg;

   localparam int DEF_INNER_NODES = 256;
   localparam int DEF_LEAF_NODES  = 256;
   localparam int FANOUT          = 256;
   localparam int STRIDE          = 8;

   localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_LOOKUP = 2'd1;
   localparam logic [1:0] MODE_FETCH  = 2'd2;
   localparam logic [1:0] MODE_NONE   = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OCCUPIED = 2'd1;
   localparam logic [1:0] ST_MISS     = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic [1:0] LVL_ROOT = 2'd0;
   localparam logic [1:0] LVL_MID  = 2'd1;
   localparam logic [1:0] LVL_LOW  = 2'd2;
   localparam logic [1:0] LVL_LEAF = 2'd3;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RD0, S_EV0, S_RD1, S_EV1, S_RD2, S_EV2,
      S_RD3, S_EV3, S_CHECK, S_ALLOC0, S_ALLOC1, S_ALLOC2, S_RESP
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_CLEAR, OP_TAKE, OP_ADVANCE, OP_ALLOC,
      OP_SLOT, OP_LOOKUP, OP_HIT, OP_FULL
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] level;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       clear_last;
      logic       link_nz;
      logic       slot_nz;
      logic       carry;
      logic       wrap_end;
      logic       pool_ok;
   } stat_type;

endpackage
`default_nettype wire

// ===== src/ipv4_multibit_trie_table.sv =====
// Top level of the IPv4 exact-match trie table: controller, datapath and stores.
//
// Request beat (req_mode, req_address, req_value) is taken when req_valid is
// high and req_stall low; one response beat (rsp_status, rsp_found_value,
// rsp_found_address, rsp_entry_count) follows for every request beat.
// One request is in flight at a time; req_stall stays high until the
// response beat has been taken, and the next request can be taken on the
// edge after that. Each trie level has a node-store read state and an examine
// state (registered RAM read). A lookup walks the levels to the leaf, or goes to
// the response early on an empty link; an insert walks the inner levels, checks
// the pools, allocates missing nodes, then updates the leaf slot (or goes to
// the response when a pool is full); the unused mode goes straight to the response.
// Fetch-next probes nodes in address order from the walk cursor, restarting at
// the root when the cursor carries; its latency grows with empty links skipped.
// After reset both stores are swept to zero, one entry per cycle, over
// max(INNER_NODES, LEAF_NODES) * 256 addresses (65536 by default); requests
// are stalled during the sweep. Pool counters, cursor and count also reset.
// A stalled response holds its beat until rsp_stall drops.
`default_nettype none
module ipv4_multibit_trie_table #(
   parameter int INNER_NODES = ipv4mt_pkg::DEF_INNER_NODES,
   parameter int LEAF_NODES  = ipv4mt_pkg::DEF_LEAF_NODES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [31:0] req_address,
   input  wire logic [31:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_found_value,
   output logic [31:0]      rsp_found_address,
   output logic [16:0]      rsp_entry_count
);

   ipv4mt_pkg::cmd_type  cmd;
   ipv4mt_pkg::stat_type stat;

   ipv4mt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_mode(req_mode),
      .req_stall(req_stall), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .stat(stat), .cmd(cmd)
   );

   ipv4mt_datapath #(.INNER_NODES(INNER_NODES), .LEAF_NODES(LEAF_NODES)) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_mode(req_mode), .req_address(req_address), .req_value(req_value),
      .rsp_status(rsp_status), .rsp_found_value(rsp_found_value),
      .rsp_found_address(rsp_found_address), .rsp_entry_count(rsp_entry_count)
   );

endmodule
`default_nettype wire

// ===== src/ipv4mt_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none
module ipv4mt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     write_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         write_data,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[addr] <= write_data;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign read_data = rdata_ff;

endmodule
`default_nettype wire

// ===== src/ipv4mt_ctrl.sv =====
// Sequencer for clearing, trie walks, node allocation and result hand-off.
`default_nettype none
module ipv4mt_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic [1:0]           req_mode,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire ipv4mt_pkg::stat_type stat,
   output ipv4mt_pkg::cmd_type       cmd
);

   ipv4mt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ipv4mt_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = ipv4mt_pkg::OP_NONE;
      cmd.level = ipv4mt_pkg::LVL_ROOT;
      case (state_ff)
         ipv4mt_pkg::S_CLEAR: begin
            cmd.op = ipv4mt_pkg::OP_CLEAR;
            if (stat.clear_last) state_in = ipv4mt_pkg::S_IDLE;
         end
         ipv4mt_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.op   = ipv4mt_pkg::OP_LOAD;
               state_in = (req_mode == ipv4mt_pkg::MODE_NONE) ? ipv4mt_pkg::S_RESP
                                                              : ipv4mt_pkg::S_RD0;
            end
         end
         ipv4mt_pkg::S_RD0: begin
            cmd.level = ipv4mt_pkg::LVL_ROOT;
            state_in  = ipv4mt_pkg::S_EV0;
         end
         ipv4mt_pkg::S_RD1: begin
            cmd.level = ipv4mt_pkg::LVL_MID;
            state_in  = ipv4mt_pkg::S_EV1;
         end
         ipv4mt_pkg::S_RD2: begin
            cmd.level = ipv4mt_pkg::LVL_LOW;
            state_in  = ipv4mt_pkg::S_EV2;
         end
         ipv4mt_pkg::S_RD3: begin
            cmd.level = ipv4mt_pkg::LVL_LEAF;
            state_in  = ipv4mt_pkg::S_EV3;
         end
         ipv4mt_pkg::S_EV0, ipv4mt_pkg::S_EV1, ipv4mt_pkg::S_EV2: begin
            cmd.level = (state_ff == ipv4mt_pkg::S_EV0) ? ipv4mt_pkg::LVL_ROOT :
                        (state_ff == ipv4mt_pkg::S_EV1) ? ipv4mt_pkg::LVL_MID  :
                                                          ipv4mt_pkg::LVL_LOW;
            if (stat.link_nz) begin
               cmd.op = ipv4mt_pkg::OP_TAKE;
               if (state_ff == ipv4mt_pkg::S_EV0) state_in = ipv4mt_pkg::S_RD1;
               else if (state_ff == ipv4mt_pkg::S_EV1) state_in = ipv4mt_pkg::S_RD2;
               else if (stat.mode == ipv4mt_pkg::MODE_INSERT) state_in = ipv4mt_pkg::S_CHECK;
               else state_in = ipv4mt_pkg::S_RD3;
            end else if (stat.mode == ipv4mt_pkg::MODE_INSERT) begin
               state_in = ipv4mt_pkg::S_CHECK;
            end else if (stat.mode == ipv4mt_pkg::MODE_FETCH) begin
               // empty subtree: step the walk key past it
               cmd.op = ipv4mt_pkg::OP_ADVANCE;
               if (stat.wrap_end || stat.carry) begin
                  state_in = stat.wrap_end ? ipv4mt_pkg::S_RESP : ipv4mt_pkg::S_RD0;
               end else begin
                  state_in = (state_ff == ipv4mt_pkg::S_EV0) ? ipv4mt_pkg::S_RD0 :
                             (state_ff == ipv4mt_pkg::S_EV1) ? ipv4mt_pkg::S_RD1 :
                                                               ipv4mt_pkg::S_RD2;
               end
            end else begin
               state_in = ipv4mt_pkg::S_RESP;
            end
         end
         ipv4mt_pkg::S_EV3: begin
            cmd.level = ipv4mt_pkg::LVL_LEAF;
            state_in  = ipv4mt_pkg::S_RESP;
            case (stat.mode)
               ipv4mt_pkg::MODE_INSERT: cmd.op = ipv4mt_pkg::OP_SLOT;
               ipv4mt_pkg::MODE_LOOKUP: cmd.op = ipv4mt_pkg::OP_LOOKUP;
               default: begin
                  if (stat.slot_nz) begin
                     cmd.op = ipv4mt_pkg::OP_HIT;
                  end else begin
                     cmd.op = ipv4mt_pkg::OP_ADVANCE;
                     if (!stat.wrap_end) begin
                        state_in = stat.carry ? ipv4mt_pkg::S_RD0 : ipv4mt_pkg::S_RD3;
                     end
                  end
               end
            endcase
         end
         ipv4mt_pkg::S_CHECK: begin
            if (stat.pool_ok) begin
               state_in = ipv4mt_pkg::S_ALLOC0;
            end else begin
               cmd.op   = ipv4mt_pkg::OP_FULL;
               state_in = ipv4mt_pkg::S_RESP;
            end
         end
         ipv4mt_pkg::S_ALLOC0: begin
            cmd.op    = ipv4mt_pkg::OP_ALLOC;
            cmd.level = ipv4mt_pkg::LVL_ROOT;
            state_in  = ipv4mt_pkg::S_ALLOC1;
         end
         ipv4mt_pkg::S_ALLOC1: begin
            cmd.op    = ipv4mt_pkg::OP_ALLOC;
            cmd.level = ipv4mt_pkg::LVL_MID;
            state_in  = ipv4mt_pkg::S_ALLOC2;
         end
         ipv4mt_pkg::S_ALLOC2: begin
            cmd.op    = ipv4mt_pkg::OP_ALLOC;
            cmd.level = ipv4mt_pkg::LVL_LOW;
            state_in  = ipv4mt_pkg::S_RD3;
         end
         ipv4mt_pkg::S_RESP: begin
            if (!rsp_stall) state_in = ipv4mt_pkg::S_IDLE;
         end
         default: state_in = ipv4mt_pkg::S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ipv4mt_pkg::S_IDLE);
   assign rsp_valid = (state_ff == ipv4mt_pkg::S_RESP);

endmodule
`default_nettype wire

// ===== src/ipv4mt_datapath.sv =====
// Node and leaf stores, key/cursor registers, pool counters and result registers.
`default_nettype none
module ipv4mt_datapath #(
   parameter int INNER_NODES = ipv4mt_pkg::DEF_INNER_NODES,
   parameter int LEAF_NODES  = ipv4mt_pkg::DEF_LEAF_NODES
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ipv4mt_pkg::cmd_type cmd,
   output ipv4mt_pkg::stat_type     stat,
   input  wire logic [1:0]          req_mode,
   input  wire logic [31:0]         req_address,
   input  wire logic [31:0]         req_value,
   output logic      [1:0]          rsp_status,
   output logic      [31:0]         rsp_found_value,
   output logic      [31:0]         rsp_found_address,
   output logic      [16:0]         rsp_entry_count
);

   localparam int IW        = $clog2(INNER_NODES);
   localparam int LW        = $clog2(LEAF_NODES + 1);
   localparam int LINK_W    = (IW > LW) ? IW : LW;
   localparam int LIW       = (LEAF_NODES > 1) ? $clog2(LEAF_NODES) : 1;
   localparam int IUW       = $clog2(INNER_NODES + 1);
   localparam int IDEPTH    = INNER_NODES * ipv4mt_pkg::FANOUT;
   localparam int LDEPTH    = LEAF_NODES * ipv4mt_pkg::FANOUT;
   localparam int IAW       = $clog2(IDEPTH);
   localparam int LAW       = $clog2(LDEPTH);
   localparam int CLR_DEPTH = (IDEPTH > LDEPTH) ? IDEPTH : LDEPTH;
   localparam int CLW       = $clog2(CLR_DEPTH);
   localparam int CW        = $clog2(LDEPTH + 1);

   // control state
   logic [IUW-1:0] inner_used_ff, inner_used_in;
   logic [LW-1:0]  leaf_used_ff, leaf_used_in;
   logic [31:0]    cursor_ff, cursor_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CLW-1:0] clr_cnt_ff, clr_cnt_in;
   // payload
   logic [1:0]     mode_ff, mode_in;
   logic [31:0]    value_ff, value_in;
   logic [31:0]    key_ff, key_in;
   logic [IW-1:0]  n1_ff, n1_in, n2_ff, n2_in;
   logic [LW-1:0]  lf_ff, lf_in;
   logic           ok1_ff, ok1_in, ok2_ff, ok2_in, okl_ff, okl_in;
   logic [1:0]     status_ff, status_in;
   logic [31:0]    fval_ff, fval_in;
   logic [31:0]    faddr_ff, faddr_in;

   logic [IAW-1:0]    inner_addr;
   logic [LAW-1:0]    leaf_addr;
   logic              inner_we, leaf_we;
   logic [LINK_W-1:0] inner_wdata, inner_rdata;
   logic [31:0]       leaf_wdata, leaf_rdata;
   logic              clr_op;
   logic [31:0]       adv_mask;
   logic [32:0]       adv_sum, adv_inc;
   logic              adv_carry;
   logic              alloc_need;
   logic [31:0]       count_wide;

   ipv4mt_ram #(.WIDTH(LINK_W), .DEPTH(IDEPTH)) u_inner_ram (
      .clock(clock), .write_en(inner_we), .addr(inner_addr),
      .write_data(inner_wdata), .read_data(inner_rdata)
   );

   ipv4mt_ram #(.WIDTH(32), .DEPTH(LDEPTH)) u_leaf_ram (
      .clock(clock), .write_en(leaf_we), .addr(leaf_addr),
      .write_data(leaf_wdata), .read_data(leaf_rdata)
   );

   assign clr_op = (cmd.op == ipv4mt_pkg::OP_CLEAR);

   always_comb begin
      if (clr_op) begin
         inner_addr = IAW'(clr_cnt_ff);
      end else begin
         case (cmd.level)
            ipv4mt_pkg::LVL_ROOT: inner_addr = {IW'(0), key_ff[31:24]};
            ipv4mt_pkg::LVL_MID:  inner_addr = {n1_ff, key_ff[23:16]};
            default:              inner_addr = {n2_ff, key_ff[15:8]};
         endcase
      end
      leaf_addr = clr_op ? LAW'(clr_cnt_ff) : {LIW'(lf_ff - LW'(1)), key_ff[7:0]};
   end

   always_comb begin
      case (cmd.level)
         ipv4mt_pkg::LVL_ROOT: begin
            adv_mask = 32'hFF00_0000; adv_inc = 33'h1_0000_00; adv_carry = &key_ff[31:24];
            alloc_need = !ok1_ff;
         end
         ipv4mt_pkg::LVL_MID: begin
            adv_mask = 32'hFFFF_0000; adv_inc = 33'h1_0000; adv_carry = &key_ff[23:16];
            alloc_need = !ok2_ff;
         end
         ipv4mt_pkg::LVL_LOW: begin
            adv_mask = 32'hFFFF_FF00; adv_inc = 33'h100; adv_carry = &key_ff[15:8];
            alloc_need = !okl_ff;
         end
         default: begin
            adv_mask = 32'hFFFF_FFFF; adv_inc = 33'h1; adv_carry = &key_ff[7:0];
            alloc_need = 1'b0;
         end
      endcase
      adv_sum = {1'b0, key_ff & adv_mask} + adv_inc;
   end

   assign inner_we = (clr_op && (32'(clr_cnt_ff) < 32'(IDEPTH))) ||
                     ((cmd.op == ipv4mt_pkg::OP_ALLOC) && alloc_need);
   assign inner_wdata = clr_op ? LINK_W'(0) :
                        (cmd.level == ipv4mt_pkg::LVL_LOW) ? LINK_W'(leaf_used_ff + LW'(1))
                                                           : LINK_W'(inner_used_ff);
   assign leaf_we = (clr_op && (32'(clr_cnt_ff) < 32'(LDEPTH))) ||
                    ((cmd.op == ipv4mt_pkg::OP_SLOT) &&
                     ((leaf_rdata == 32'd0) || (value_ff == 32'd0)));
   assign leaf_wdata = clr_op ? 32'd0 : value_ff;

   always_comb begin
      inner_used_in = inner_used_ff;
      leaf_used_in  = leaf_used_ff;
      cursor_in     = cursor_ff;
      count_in      = count_ff;
      clr_cnt_in    = clr_cnt_ff;
      mode_in       = mode_ff;
      value_in      = value_ff;
      key_in        = key_ff;
      n1_in         = n1_ff;
      n2_in         = n2_ff;
      lf_in         = lf_ff;
      ok1_in        = ok1_ff;
      ok2_in        = ok2_ff;
      okl_in        = okl_ff;
      status_in     = status_ff;
      fval_in       = fval_ff;
      faddr_in      = faddr_ff;
      case (cmd.op)
         ipv4mt_pkg::OP_LOAD: begin
            mode_in   = req_mode;
            value_in  = req_value;
            key_in    = (req_mode == ipv4mt_pkg::MODE_FETCH) ? cursor_ff : req_address;
            ok1_in    = 1'b0;
            ok2_in    = 1'b0;
            okl_in    = 1'b0;
            status_in = ipv4mt_pkg::ST_MISS;
            fval_in   = 32'd0;
            faddr_in  = req_address;
         end
         ipv4mt_pkg::OP_CLEAR: clr_cnt_in = clr_cnt_ff + CLW'(1);
         ipv4mt_pkg::OP_TAKE: begin
            case (cmd.level)
               ipv4mt_pkg::LVL_ROOT: begin n1_in = inner_rdata[IW-1:0]; ok1_in = 1'b1; end
               ipv4mt_pkg::LVL_MID:  begin n2_in = inner_rdata[IW-1:0]; ok2_in = 1'b1; end
               default:              begin lf_in = inner_rdata[LW-1:0]; okl_in = 1'b1; end
            endcase
         end
         ipv4mt_pkg::OP_ADVANCE: begin
            if (adv_sum[32]) cursor_in = 32'd0;
            else key_in = adv_sum[31:0];
         end
         ipv4mt_pkg::OP_ALLOC: begin
            if (alloc_need) begin
               case (cmd.level)
                  ipv4mt_pkg::LVL_ROOT: begin
                     n1_in = IW'(inner_used_ff); ok1_in = 1'b1;
                     inner_used_in = inner_used_ff + IUW'(1);
                  end
                  ipv4mt_pkg::LVL_MID: begin
                     n2_in = IW'(inner_used_ff); ok2_in = 1'b1;
                     inner_used_in = inner_used_ff + IUW'(1);
                  end
                  default: begin
                     lf_in = leaf_used_ff + LW'(1); okl_in = 1'b1;
                     leaf_used_in = leaf_used_ff + LW'(1);
                  end
               endcase
            end
         end
         ipv4mt_pkg::OP_SLOT: begin
            if (leaf_rdata == 32'd0) begin
               status_in = ipv4mt_pkg::ST_OK;
               if (value_ff != 32'd0) count_in = count_ff + CW'(1);
            end else if (value_ff == 32'd0) begin
               status_in = ipv4mt_pkg::ST_OK;
               count_in  = count_ff - CW'(1);
            end else begin
               status_in = ipv4mt_pkg::ST_OCCUPIED;
            end
         end
         ipv4mt_pkg::OP_LOOKUP: begin
            if (leaf_rdata != 32'd0) begin
               status_in = ipv4mt_pkg::ST_OK;
               fval_in   = leaf_rdata;
            end
         end
         ipv4mt_pkg::OP_HIT: begin
            status_in = ipv4mt_pkg::ST_OK;
            fval_in   = leaf_rdata;
            faddr_in  = key_ff;
            cursor_in = key_ff + 32'd1;
         end
         ipv4mt_pkg::OP_FULL: status_in = ipv4mt_pkg::ST_FULL;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_used_ff <= IUW'(1);
         leaf_used_ff  <= '0;
         cursor_ff     <= '0;
         count_ff      <= '0;
         clr_cnt_ff    <= '0;
      end else begin
         inner_used_ff <= inner_used_in;
         leaf_used_ff  <= leaf_used_in;
         cursor_ff     <= cursor_in;
         count_ff      <= count_in;
         clr_cnt_ff    <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      value_ff  <= value_in;
      key_ff    <= key_in;
      n1_ff     <= n1_in;
      n2_ff     <= n2_in;
      lf_ff     <= lf_in;
      ok1_ff    <= ok1_in;
      ok2_ff    <= ok2_in;
      okl_ff    <= okl_in;
      status_ff <= status_in;
      fval_ff   <= fval_in;
      faddr_ff  <= faddr_in;
   end

   assign stat.mode       = mode_ff;
   assign stat.clear_last = (clr_cnt_ff == CLW'(CLR_DEPTH - 1));
   assign stat.link_nz    = |inner_rdata;
   assign stat.slot_nz    = |leaf_rdata;
   assign stat.carry      = adv_carry;
   assign stat.wrap_end   = adv_sum[32];
   assign stat.pool_ok    =
      ((32'(inner_used_ff) + 32'(!ok1_ff) + 32'(!ok2_ff)) <= 32'(INNER_NODES)) &&
      ((32'(leaf_used_ff) + 32'(!okl_ff)) <= 32'(LEAF_NODES));

   assign count_wide        = 32'(count_ff);
   assign rsp_entry_count   = (count_wide > 32'(ipv4mt_pkg::COUNT_MAX)) ?
                              ipv4mt_pkg::COUNT_MAX : count_wide[16:0];
   assign rsp_status        = status_ff;
   assign rsp_found_value   = fval_ff;
   assign rsp_found_address = faddr_ff;

endmodule
`default_nettype wire

// ===== src/ipv4mt_checker.sv =====
// Port-level checks for the trie table, bound to the top level.
`default_nettype none
module ipv4mt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [1:0]  req_mode,
   input wire logic [31:0] req_address,
   input wire logic [31:0] req_value,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_status,
   input wire logic [31:0] rsp_found_value,
   input wire logic [31:0] rsp_found_address,
   input wire logic [16:0] rsp_entry_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_found_value) && $stable(rsp_found_address))
      else $error("stalled response beat changed");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a response is pending");

   a_no_value_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ipv4mt_pkg::ST_OK) |-> rsp_found_value == 32'd0)
      else $error("value returned with a failing status");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_stall)
      else $error("block active right after reset");

endmodule

bind ipv4_multibit_trie_table ipv4mt_checker u_checker (.*);
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the IPv4 multibit trie table.
`timescale 1ns / 1ps
module tb;

   localparam int  POOL_INNER = ipv4mt_pkg::DEF_INNER_NODES;
   localparam int  POOL_LEAF  = ipv4mt_pkg::DEF_LEAF_NODES;
   localparam int  NODE_FAN   = ipv4mt_pkg::FANOUT;
   localparam int  DRAIN_CYCLES = 64;
   localparam longint CYCLE_LIMIT = 4_000_000;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] found_value;
      logic [31:0] found_address;
      logic [16:0] entry_count;
   } trie_result_type;

   logic        clock;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic [1:0]  req_mode     = ipv4mt_pkg::MODE_LOOKUP;
   logic [31:0] req_address  = '0;
   logic [31:0] req_value    = '0;
   logic        rsp_stall    = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_found_value;
   logic [31:0] rsp_found_address;
   logic [16:0] rsp_entry_count;

   ipv4_multibit_trie_table u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_address(req_address), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_found_value(rsp_found_value), .rsp_found_address(rsp_found_address),
      .rsp_entry_count(rsp_entry_count)
   );

   // shadow trie
   bit [15:0] node_links [POOL_INNER * NODE_FAN];
   bit [31:0] slot_values [POOL_LEAF * NODE_FAN];
   int unsigned inner_taken = 1;
   int unsigned leaf_taken  = 0;
   bit [31:0]   cursor      = '0;
   int unsigned live_entries = 0;

   trie_result_type pending_results[$];
   int  mismatches = 0;
   int  beats_sent = 0;
   int  beats_seen = 0;
   int  status_seen [4] = '{0, 0, 0, 0};
   bit  quiet = 1'b0;          // no idling on either side
   int  hold_cycles = 0;       // forced receiver hold-off
   longint cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout, %0d results outstanding", $time, pending_results.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic int unsigned inner_child(int unsigned node, int unsigned idx);
      int unsigned l;
      l = node_links[node * NODE_FAN + idx];
      return (l != 0 && l < POOL_INNER) ? l : 0;
   endfunction

   function automatic int unsigned leaf_child(int unsigned node, int unsigned idx);
      int unsigned l;
      l = node_links[node * NODE_FAN + idx];
      return (l != 0 && l <= POOL_LEAF) ? l : 0;
   endfunction

   function automatic logic [1:0] trie_insert(logic [31:0] a, logic [31:0] v);
      int unsigned n1, n2, lf, need_i, need_l, k;
      n1 = inner_child(0, a[31:24]);
      n2 = n1 ? inner_child(n1, a[23:16]) : 0;
      lf = n2 ? leaf_child(n2, a[15:8]) : 0;
      need_i = (n1 == 0) + (n2 == 0);
      need_l = (lf == 0);
      if (inner_taken + need_i > POOL_INNER || leaf_taken + need_l > POOL_LEAF)
         return ipv4mt_pkg::ST_FULL;
      if (n1 == 0) begin
         n1 = inner_taken++;
         for (k = 0; k < NODE_FAN; k++) node_links[n1 * NODE_FAN + k] = 0;
         node_links[a[31:24]] = 16'(n1);
      end
      if (n2 == 0) begin
         n2 = inner_taken++;
         for (k = 0; k < NODE_FAN; k++) node_links[n2 * NODE_FAN + k] = 0;
         node_links[n1 * NODE_FAN + a[23:16]] = 16'(n2);
      end
      if (lf == 0) begin
         for (k = 0; k < NODE_FAN; k++) slot_values[leaf_taken * NODE_FAN + k] = 0;
         lf = ++leaf_taken;
         node_links[n2 * NODE_FAN + a[15:8]] = 16'(lf);
      end
      k = (lf - 1) * NODE_FAN + a[7:0];
      if (slot_values[k] == 0) begin
         slot_values[k] = v;
         if (v != 0) live_entries++;
         return ipv4mt_pkg::ST_OK;
      end
      if (v == 0) begin
         slot_values[k] = 0;
         live_entries--;
         return ipv4mt_pkg::ST_OK;
      end
      return ipv4mt_pkg::ST_OCCUPIED;
   endfunction

   function automatic logic [31:0] trie_lookup(logic [31:0] a);
      int unsigned n1, n2, lf;
      n1 = inner_child(0, a[31:24]);
      n2 = n1 ? inner_child(n1, a[23:16]) : 0;
      lf = n2 ? leaf_child(n2, a[15:8]) : 0;
      return lf ? slot_values[(lf - 1) * NODE_FAN + a[7:0]] : 32'd0;
   endfunction

   // next occupied address at or above the cursor
   function automatic bit trie_walk(output logic [31:0] a, output logic [31:0] v);
      int unsigned i0, i1, i2, i3, n1, n2, lf;
      bit t1, t2, t3;
      for (i0 = cursor[31:24]; i0 < 256; i0++) begin
         t1 = (i0 == cursor[31:24]);
         n1 = inner_child(0, i0);
         if (n1 == 0) continue;
         for (i1 = t1 ? cursor[23:16] : 0; i1 < 256; i1++) begin
            t2 = t1 && i1 == cursor[23:16];
            n2 = inner_child(n1, i1);
            if (n2 == 0) continue;
            for (i2 = t2 ? cursor[15:8] : 0; i2 < 256; i2++) begin
               t3 = t2 && i2 == cursor[15:8];
               lf = leaf_child(n2, i2);
               if (lf == 0) continue;
               for (i3 = t3 ? cursor[7:0] : 0; i3 < 256; i3++) begin
                  if (slot_values[(lf - 1) * NODE_FAN + i3] == 0) continue;
                  a = {i0[7:0], i1[7:0], i2[7:0], i3[7:0]};
                  v = slot_values[(lf - 1) * NODE_FAN + i3];
                  cursor = a + 32'd1;
                  return 1'b1;
               end
            end
         end
      end
      cursor = '0;
      return 1'b0;
   endfunction

   function automatic trie_result_type predict_trie_op(logic [1:0] mode, logic [31:0] a,
                                                       logic [31:0] v);
      trie_result_type r;
      logic [31:0] wa, wv;
      r.status = ipv4mt_pkg::ST_MISS;
      r.found_value = '0;
      r.found_address = a;
      case (mode)
         ipv4mt_pkg::MODE_INSERT: r.status = trie_insert(a, v);
         ipv4mt_pkg::MODE_LOOKUP: begin
            r.found_value = trie_lookup(a);
            r.status = (r.found_value != 0) ? ipv4mt_pkg::ST_OK : ipv4mt_pkg::ST_MISS;
         end
         ipv4mt_pkg::MODE_FETCH: begin
            if (trie_walk(wa, wv)) begin
               r.status = ipv4mt_pkg::ST_OK;
               r.found_value = wv;
               r.found_address = wa;
            end
         end
         default: ;
      endcase
      r.entry_count = (live_entries > ipv4mt_pkg::COUNT_MAX) ? ipv4mt_pkg::COUNT_MAX
                                                              : live_entries[16:0];
      return r;
   endfunction

   function automatic int pick_gap();
      int p;
      if (quiet) return 0;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_op(input logic [1:0] mode, input logic [31:0] a,
                          input logic [31:0] v);
      int gap;
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_address <= a;
      req_value   <= v;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(predict_trie_op(mode, a, v));
      beats_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // receiver stall pattern
   int stall_left = 0;
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 99) < 30)
            stall_left <= ($urandom_range(0, 99) < 95) ? $urandom_range(1, 3)
                                                       : $urandom_range(15, 50);
      end
   end

   always @(posedge clock) begin
      trie_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         status_seen[rsp_status]++;
         if (pending_results.size() == 0) begin
            $display("%0t unexpected response beat status %0d", $time, rsp_status);
            mismatches++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t status: expected %0d actual %0d", $time, e.status, rsp_status);
               mismatches++;
            end
            if (rsp_found_value !== e.found_value) begin
               $display("%0t found_value: expected %h actual %h", $time,
                        e.found_value, rsp_found_value);
               mismatches++;
            end
            if (rsp_found_address !== e.found_address) begin
               $display("%0t found_address: expected %h actual %h", $time,
                        e.found_address, rsp_found_address);
               mismatches++;
            end
            if (rsp_entry_count !== e.entry_count) begin
               $display("%0t entry_count: expected %0d actual %0d", $time,
                        e.entry_count, rsp_entry_count);
               mismatches++;
            end
         end
      end
   end

   // keys drawn mostly from a few prefixes so entries collide and get revisited
   function automatic logic [31:0] pick_key();
      logic [7:0] o0, o1, o2, o3;
      if ($urandom_range(0, 99) < 4) return $urandom();
      case ($urandom_range(0, 3))
         0: o0 = 8'h00; 1: o0 = 8'h0a; 2: o0 = 8'hc0; default: o0 = 8'hff;
      endcase
      case ($urandom_range(0, 2))
         0: o1 = 8'h00; 1: o1 = 8'ha5; default: o1 = 8'hff;
      endcase
      case ($urandom_range(0, 2))
         0: o2 = 8'h00; 1: o2 = 8'h5a; default: o2 = 8'hff;
      endcase
      o3 = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 23)) : 8'($urandom());
      return {o0, o1, o2, o3};
   endfunction

   task automatic test_directed();
      send_op(ipv4mt_pkg::MODE_LOOKUP, 32'h0000_0000, 32'h0);
      send_op(ipv4mt_pkg::MODE_FETCH,  32'h1234_5678, 32'h0);
      send_op(ipv4mt_pkg::MODE_INSERT, 32'h0000_0000, 32'h0000_0001);
      send_op(ipv4mt_pkg::MODE_INSERT, 32'hffff_ffff, 32'hffff_ffff);
      send_op(ipv4mt_pkg::MODE_INSERT, 32'h0000_0000, 32'hdead_beef);   // occupied
      send_op(ipv4mt_pkg::MODE_INSERT, 32'h8040_2010, 32'h0);   // zero into empty slot
      send_op(ipv4mt_pkg::MODE_LOOKUP, 32'h8040_2010, 32'h0);
      send_op(ipv4mt_pkg::MODE_LOOKUP, 32'hffff_ffff, 32'hffff_ffff);
      send_op(ipv4mt_pkg::MODE_LOOKUP, 32'h0000_0001, 32'h0);
      send_op(ipv4mt_pkg::MODE_INSERT, 32'h0000_00ff, 32'h5555_aaaa);
      send_op(ipv4mt_pkg::MODE_FETCH,  32'hffff_ffff, 32'h0);
      send_op(ipv4mt_pkg::MODE_FETCH,  32'h0,         32'h0);
      send_op(ipv4mt_pkg::MODE_FETCH,  32'h0,         32'h0);
      send_op(ipv4mt_pkg::MODE_FETCH,  32'h0,         32'h0);           // restarts from the bottom after the wrap
      send_op(ipv4mt_pkg::MODE_INSERT, 32'h0000_0000, 32'h0);           // clear an entry
      send_op(ipv4mt_pkg::MODE_LOOKUP, 32'h0000_0000, 32'h0);
      send_op(ipv4mt_pkg::MODE_NONE,   32'hffff_ffff, 32'hffff_ffff);
      send_op(ipv4mt_pkg::MODE_NONE,   32'h0,         32'h0);
      send_op(ipv4mt_pkg::MODE_FETCH,  32'h0,         32'h0);
      send_op(ipv4mt_pkg::MODE_FETCH,  32'h0,         32'h0);
      send_op(ipv4mt_pkg::MODE_FETCH,  32'h0,         32'h0);           // wraps round to the first entry
   endtask

   task automatic test_random(input int count);
      int i, p;
      logic [31:0] v;
      for (i = 0; i < count; i++) begin
         if (i % 250 == 0) quiet = ($urandom_range(0, 2) == 0);
         p = $urandom_range(0, 99);
         v = ($urandom_range(0, 99) < 20) ? 32'h0 : $urandom();
         if (p < 45)      send_op(ipv4mt_pkg::MODE_INSERT, pick_key(), v);
         else if (p < 80) send_op(ipv4mt_pkg::MODE_LOOKUP, pick_key(), $urandom());
         else if (p < 96) send_op(ipv4mt_pkg::MODE_FETCH, $urandom(), $urandom());
         else             send_op(ipv4mt_pkg::MODE_NONE, $urandom(), $urandom());
      end
      quiet = 1'b0;
   endtask

   // receiver holds off while requests keep coming, so the input backs up
   task automatic test_backpressure();
      int i;
      hold_cycles = 400;
      for (i = 0; i < 12; i++) send_op(ipv4mt_pkg::MODE_LOOKUP, pick_key(), 32'h0);
   endtask

   // exhaust the interior pool, then the leaf pool
   task automatic test_pool_exhaustion();
      int i;
      for (i = 0; i < 256; i++)
         send_op(ipv4mt_pkg::MODE_INSERT, {8'(i), 8'h77, 8'h33, 8'h01}, 32'(i + 1));
      for (i = 0; i < 256; i++)
         send_op(ipv4mt_pkg::MODE_INSERT, {8'h00, 8'h00, 8'(i), 8'h80}, 32'h100 + 32'(i));
      send_op(ipv4mt_pkg::MODE_INSERT, 32'h0a00_0001, 32'h0);
      for (i = 0; i < 6; i++) send_op(ipv4mt_pkg::MODE_FETCH, 32'h0, 32'h0);
      send_op(ipv4mt_pkg::MODE_LOOKUP, {8'd200, 8'h77, 8'h33, 8'h01}, 32'h0);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(750);
      test_backpressure();
      test_pool_exhaustion();
      req_valid <= 1'b0;
      while (pending_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests, checked %0d responses (ok %0d, occupied %0d, miss %0d,",
               beats_sent, beats_seen, status_seen[ipv4mt_pkg::ST_OK],
               status_seen[ipv4mt_pkg::ST_OCCUPIED], status_seen[ipv4mt_pkg::ST_MISS]);
      $display("pool full %0d); %0d entries live, %0d mismatches.",
               status_seen[ipv4mt_pkg::ST_FULL], live_entries, mismatches);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
